@@ src/clfo_pkg.sv @@
// Shared types, register codes and constants for the curve LFO with start delay.
// Holds the quarter-wave sine generator used to build the ROM at elaboration.
// No dependencies.
`default_nettype none

package clfo_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_DEPTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SPEED = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DELAY = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RANGE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CURVE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_START = 3'd5;

   localparam logic [2:0] CURVE_SINE   = 3'd0;
   localparam logic [2:0] CURVE_TRI    = 3'd1;
   localparam logic [2:0] CURVE_SAW    = 3'd2;
   localparam logic [2:0] CURVE_SQUARE = 3'd3;
   localparam logic [2:0] CURVE_RANDOM = 3'd4;

   localparam logic [23:0] SPEED_RESET = 24'd409600;
   localparam logic [16:0] ONE_Q16     = 17'd65536;
   localparam logic [10:0] MS_PER_SEC  = 11'd1000;
   localparam logic [63:0] PI_Q30      = 64'd3373259426;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_ADV,
      ST_ROM,
      ST_CURVE,
      ST_SCALE,
      ST_DONE
   } clfo_state_type;

   typedef struct packed {
      logic load_req;
      logic prep;
      logic div_step;
      logic adv;
      logic rom_read;
      logic curve;
      logic scale;
      logic out_load;
   } clfo_cmd_type;

   // Taylor series of sin(pi/2 * k / 2^stb) in Q30, rounded to Q16.
   function automatic logic [16:0] sine_entry(input int unsigned k, input int unsigned stb);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        r;
      logic signed [63:0] sum;
      x    = (PI_Q30 * 64'(k)) >> (stb + 1);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd342; sum = sum - $signed(term);
      if (sum[63]) begin
         sum = '0;
      end
      r = ($unsigned(sum) + 64'd8192) >> 14;
      if (r > 64'd65536) begin
         r = 64'd65536;
      end
      return r[16:0];
   endfunction

endpackage

`default_nettype wire

@@ src/clfo_ifs.sv @@
// Handshake channel interfaces: tick request, LFO result and register write.
// Depends on clfo_pkg for the register port widths.
`default_nettype none

interface clfo_req_if;
   logic        valid;
   logic        ready;
   logic        restart;
   logic [15:0] elapsed_ms;
   logic [15:0] random_sample;
   modport source (output valid, restart, elapsed_ms, random_sample, input ready);
   modport sink (input valid, restart, elapsed_ms, random_sample, output ready);
endinterface

interface clfo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] lfo_value;
   logic               cycle_wrapped;
   modport source (output valid, lfo_value, cycle_wrapped, input ready);
   modport sink (input valid, lfo_value, cycle_wrapped, output ready);
endinterface

interface clfo_csr_if;
   logic                               valid;
   logic                               ready;
   logic [clfo_pkg::CSR_INDEX_W-1:0]   index;
   logic [clfo_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/clfo_ctrl.sv @@
// Sequencer for one tick: prepare, divide, advance, ROM read, curve, scale, deliver.
// Depends on clfo_pkg for the state and command types.
`default_nettype none

module clfo_ctrl #(
   parameter int DIV_STEPS = 7
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output clfo_pkg::clfo_cmd_type cmd
);

   localparam int CW = $clog2(DIV_STEPS);

   clfo_pkg::clfo_state_type state_ff, state_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         clfo_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = clfo_pkg::ST_PREP;
            end
         end
         clfo_pkg::ST_PREP:  state_in = clfo_pkg::ST_DIV;
         clfo_pkg::ST_DIV: begin
            if (cnt_ff == CW'(DIV_STEPS - 1)) begin
               state_in = clfo_pkg::ST_ADV;
            end
         end
         clfo_pkg::ST_ADV:   state_in = clfo_pkg::ST_ROM;
         clfo_pkg::ST_ROM:   state_in = clfo_pkg::ST_CURVE;
         clfo_pkg::ST_CURVE: state_in = clfo_pkg::ST_SCALE;
         clfo_pkg::ST_SCALE: state_in = clfo_pkg::ST_DONE;
         clfo_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = clfo_pkg::ST_IDLE;
            end
         end
         default: state_in = clfo_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         clfo_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         clfo_pkg::ST_PREP:  cmd.prep     = 1'b1;
         clfo_pkg::ST_DIV:   cmd.div_step = 1'b1;
         clfo_pkg::ST_ADV:   cmd.adv      = 1'b1;
         clfo_pkg::ST_ROM:   cmd.rom_read = 1'b1;
         clfo_pkg::ST_CURVE: cmd.curve    = 1'b1;
         clfo_pkg::ST_SCALE: cmd.scale    = 1'b1;
         clfo_pkg::ST_DONE:  cmd.out_load = out_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      cnt_in = (state_ff == clfo_pkg::ST_DIV) ? cnt_ff + CW'(1) : '0;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clfo_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ src/clfo_dp.sv @@
// Datapath: config registers, delay counter, phase accumulator, divide-by-1000,
// sine ROM, curve select and depth/range scaling. Depends on clfo_pkg.
`default_nettype none

module clfo_dp #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int PHASE_BITS      = 32,
   parameter int DIV_STEPS       = 7
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  clfo_pkg::clfo_cmd_type              cmd,
   input  wire                                 cfg_we,
   input  wire [clfo_pkg::CSR_INDEX_W-1:0]     cfg_index,
   input  wire [clfo_pkg::CSR_DATA_W-1:0]      cfg_data,
   input  wire                                 req_restart,
   input  wire [15:0]                          req_elapsed_ms,
   input  wire [15:0]                          req_random_sample,
   output logic signed [31:0]                  rsp_lfo_value,
   output logic                                rsp_cycle_wrapped
);

   localparam int PB     = PHASE_BITS;
   localparam int STB    = SINE_TABLE_BITS;
   localparam int SINE_N = 1 << STB;
   localparam int DIVW   = DIV_STEPS * 8;
   localparam int SEED_R = 1 << (PHASE_BITS % 7);
   localparam logic [PB-1:0] SEED_Q = PB'(((65'd1 << PHASE_BITS) - 65'(SEED_R)) / 127);

   // configuration
   logic signed [23:0] depth_ff;
   logic [23:0]        speed_ff;
   logic [15:0]        delay_ff;
   logic [7:0]         range_ff;
   logic [2:0]         curve_ff;
   logic [6:0]         start_ff;

   // tick payload and oscillator state
   logic               restart_ff;
   logic [15:0]        ms_ff;
   logic [15:0]        sample_ff;
   logic [PB:0]        phase_ff, phase_in;
   logic               started_ff, started_in;
   logic               wrapped_ff, wrapped_in;
   logic [16:0]        held_ff, held_in;
   logic [15:0]        dcount_ff, dcount_in;
   logic               adv_ff, adv_in;

   // working registers
   logic [DIVW-1:0]    div_ff, div_in;
   logic [9:0]         rem_ff, rem_in;
   logic [16:0]        rom_ff;
   logic signed [41:0] prod_ff;
   logic [31:0]        result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         speed_ff <= clfo_pkg::SPEED_RESET;
         delay_ff <= '0;
         range_ff <= 8'd1;
         curve_ff <= clfo_pkg::CURVE_SINE;
         start_ff <= '0;
      end else if (cfg_we) begin
         case (cfg_index)
            clfo_pkg::REG_DEPTH: depth_ff <= $signed(cfg_data[23:0]);
            clfo_pkg::REG_SPEED: speed_ff <= cfg_data[23:0];
            clfo_pkg::REG_DELAY: delay_ff <= cfg_data[15:0];
            clfo_pkg::REG_RANGE: range_ff <= cfg_data[7:0];
            clfo_pkg::REG_CURVE: curve_ff <= cfg_data[2:0];
            clfo_pkg::REG_START: start_ff <= cfg_data[6:0];
            default: ;
         endcase
      end
   end

   // seed = floor(start * 2^PB / 127) = start*Q + floor(start*R / 127)
   logic [PB+7:0] seed_prod;
   logic [12:0]   seed_x;
   logic [7:0]    seed_rem;
   logic [6:0]    seed_lo;
   logic [PB:0]   seed;

   assign seed_prod = (PB+8)'(start_ff) * (PB+8)'(SEED_Q);
   assign seed_x    = 13'(start_ff) * 13'(SEED_R);
   assign seed_rem  = 8'(seed_x[6:0]) + 8'(seed_x[12:7]);
   assign seed_lo   = 7'(seed_x[12:7]) + ((seed_rem >= 8'd127) ? 7'd1 : 7'd0);
   assign seed      = seed_prod[PB:0] + (PB+1)'(seed_lo);

   // restart and delay handling
   logic [15:0] eff_dc;
   logic [PB:0] eff_phase;
   logic        eff_started;
   logic        eff_wrapped;
   logic [16:0] eff_held;
   logic [16:0] dly_sum;
   logic [15:0] ms_rem;
   logic [15:0] dc_prep;
   logic        advance;
   logic        do_adv;
   logic [39:0] inc_prod;

   always_comb begin
      eff_dc      = restart_ff ? '0 : dcount_ff;
      eff_phase   = restart_ff ? '0 : phase_ff;
      eff_started = restart_ff ? 1'b0 : started_ff;
      eff_wrapped = restart_ff ? 1'b0 : wrapped_ff;
      eff_held    = restart_ff ? clfo_pkg::ONE_Q16 : held_ff;
      dly_sum     = {1'b0, eff_dc} + {1'b0, ms_ff};
      ms_rem      = ms_ff;
      dc_prep     = eff_dc;
      advance     = 1'b1;
      if (eff_dc < delay_ff) begin
         if (dly_sum <= {1'b0, delay_ff}) begin
            dc_prep = dly_sum[15:0];
            advance = 1'b0;
         end else begin
            ms_rem  = ms_ff - (delay_ff - eff_dc);
            dc_prep = delay_ff;
         end
      end
      do_adv = advance && (speed_ff != '0);
   end

   assign inc_prod = 40'(speed_ff) * 40'(ms_rem);

   // eight quotient bits of the divide by 1000 per step
   logic [DIVW-1:0] quo_v;
   logic [9:0]      rem_v;
   logic [10:0]     rem_w;

   always_comb begin
      quo_v = div_ff;
      rem_v = rem_ff;
      rem_w = '0;
      for (int b = 0; b < 8; b++) begin
         rem_w = {rem_v, quo_v[DIVW-1]};
         quo_v = {quo_v[DIVW-2:0], 1'b0};
         if (rem_w >= clfo_pkg::MS_PER_SEC) begin
            rem_w    = rem_w - clfo_pkg::MS_PER_SEC;
            quo_v[0] = 1'b1;
         end
         rem_v = rem_w[9:0];
      end
   end

   logic [DIVW-1:0] adv_sum;
   assign adv_sum = DIVW'(phase_ff) + div_ff;

   // sine ROM
   logic [16:0]    sine_tbl [SINE_N+1];
   logic [31:0]    sine_a32;
   logic [1:0]     quad;
   logic [STB-1:0] sidx;
   logic [STB:0]   saddr;

   for (genvar k = 0; k <= SINE_N; k++) begin : g_sine
      assign sine_tbl[k] = clfo_pkg::sine_entry(k, STB);
   end

   assign sine_a32 = 32'(phase_ff[PB-1:0]) << (32 - PB);
   assign quad     = sine_a32[31:30];
   assign sidx     = sine_a32[29:30-STB];
   assign saddr    = quad[0] ? ((STB+1)'(SINE_N) - {1'b0, sidx}) : {1'b0, sidx};

   // curve value
   logic [PB+17:0]     tri_wide;
   logic [17:0]        tri_t;
   logic signed [18:0] tri_v;
   logic               produce;
   logic               latch_rnd;
   logic signed [17:0] curve_val;
   logic signed [41:0] prod_mul;

   assign tri_wide = {phase_ff[PB-1:0], 18'b0};
   assign tri_t    = tri_wide[PB+17:PB];
   assign produce  = (depth_ff != '0) && (dcount_ff >= delay_ff);
   assign latch_rnd = produce && (curve_ff == clfo_pkg::CURVE_RANDOM) && wrapped_ff;

   always_comb begin
      case (phase_ff[PB-1:PB-2])
         2'd0:    tri_v = $signed({1'b0, tri_t});
         2'd3:    tri_v = $signed({1'b0, tri_t}) - 19'sd262144;
         default: tri_v = 19'sd131072 - $signed({1'b0, tri_t});
      endcase
      case (curve_ff)
         clfo_pkg::CURVE_SINE:
            curve_val = quad[1] ? -$signed({1'b0, rom_ff}) : $signed({1'b0, rom_ff});
         clfo_pkg::CURVE_TRI:    curve_val = tri_v[17:0];
         clfo_pkg::CURVE_SAW:    curve_val = $signed({2'b0, phase_ff[PB-1:PB-16]});
         clfo_pkg::CURVE_SQUARE:
            curve_val = phase_ff[PB-1] ? $signed({1'b0, clfo_pkg::ONE_Q16}) : 18'sd0;
         clfo_pkg::CURVE_RANDOM:
            curve_val = latch_rnd ? $signed({2'b0, sample_ff}) : $signed({1'b0, held_ff});
         default:                curve_val = $signed({1'b0, clfo_pkg::ONE_Q16});
      endcase
      if (!produce) begin
         curve_val = '0;
      end
   end

   assign prod_mul = curve_val * depth_ff;

   // truncate toward zero, then apply range
   logic signed [41:0] prod_adj;
   logic signed [25:0] scaled;
   logic signed [34:0] ranged;

   assign prod_adj = prod_ff + (prod_ff[41] ? 42'sd65535 : 42'sd0);
   assign scaled   = prod_adj[41:16];
   assign ranged   = scaled * $signed({1'b0, range_ff});

   // oscillator state next values
   always_comb begin
      phase_in   = phase_ff;
      started_in = started_ff;
      wrapped_in = wrapped_ff;
      held_in    = held_ff;
      dcount_in  = dcount_ff;
      adv_in     = adv_ff;
      if (cmd.prep) begin
         phase_in   = (do_adv && !eff_started) ? seed : eff_phase;
         started_in = eff_started || do_adv;
         wrapped_in = eff_wrapped;
         held_in    = eff_held;
         dcount_in  = dc_prep;
         adv_in     = do_adv;
      end else if (cmd.adv && adv_ff) begin
         phase_in   = {1'b0, adv_sum[PB-1:0]};
         wrapped_in = |adv_sum[DIVW-1:PB];
      end else if (cmd.curve && latch_rnd) begin
         held_in    = {1'b0, sample_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         started_ff <= 1'b0;
         wrapped_ff <= 1'b0;
         held_ff    <= clfo_pkg::ONE_Q16;
         dcount_ff  <= '0;
         adv_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         started_ff <= started_in;
         wrapped_ff <= wrapped_in;
         held_ff    <= held_in;
         dcount_ff  <= dcount_in;
         adv_ff     <= adv_in;
      end
   end

   always_comb begin
      div_in = div_ff;
      rem_in = rem_ff;
      if (cmd.prep) begin
         div_in = DIVW'(inc_prod) << (PB - 16);
         rem_in = '0;
      end else if (cmd.div_step) begin
         div_in = quo_v;
         rem_in = rem_v;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
      if (cmd.load_req) begin
         restart_ff <= req_restart;
         ms_ff      <= req_elapsed_ms;
         sample_ff  <= req_random_sample;
      end
      if (cmd.rom_read) begin
         rom_ff <= sine_tbl[saddr];
      end
      if (cmd.curve) begin
         prod_ff <= prod_mul;
      end
      if (cmd.scale) begin
         result_ff <= ranged[31:0];
      end
      if (cmd.out_load) begin
         rsp_lfo_value     <= $signed(result_ff);
         rsp_cycle_wrapped <= wrapped_ff;
      end
   end

endmodule

`default_nettype wire

@@ src/curve_lfo_with_delay.sv @@
// Curve LFO with start delay: top level joining the sequencer and the datapath.
// Depends on clfo_pkg, clfo_ifs (channel interfaces), clfo_ctrl and clfo_dp.
//
// Usage:
//   req_ch  - one transfer per tick: restart, elapsed_ms, random_sample.
//   rsp_ch  - one transfer per tick: lfo_value (signed Q15.16), cycle_wrapped.
//   csr_ch  - register writes (index 0 depth, 1 speed, 2 delay, 3 range,
//             4 curve, 5 start phase); always ready, write only while idle.
// DIV_STEPS = ceil((PHASE_BITS+24)/8) divide steps. The divide by 1000 of the phase
//   increment resolves eight quotient bits per cycle. After the request transfer
//   the tick passes through PREP, DIV, ADV, ROM, CURVE, SCALE and DONE, and the
//   result is then presented from the output register.
// One tick is in flight at a time. The result sits in an output register, so
//   the next request is taken while it waits; a stalled receiver holds the
//   following tick in its last step until the output register frees.
// Reset (synchronous) restores the control and configuration registers to their
//   reset values and clears the oscillator state; no clearing pass follows.
`default_nettype none

module curve_lfo_with_delay #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int PHASE_BITS      = 32
) (
   input wire          clock,
   input wire          reset,
   clfo_req_if.sink    req_ch,
   clfo_rsp_if.source  rsp_ch,
   clfo_csr_if.sink    csr_ch
);

   localparam int DIV_STEPS = (PHASE_BITS + 24 + 7) / 8;

   clfo_pkg::clfo_cmd_type cmd;
   logic                   cfg_we;

   assign csr_ch.ready = 1'b1;
   assign cfg_we       = csr_ch.valid && csr_ch.ready;

   clfo_ctrl #(
      .DIV_STEPS (DIV_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   clfo_dp #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .PHASE_BITS      (PHASE_BITS),
      .DIV_STEPS       (DIV_STEPS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg_we            (cfg_we),
      .cfg_index         (csr_ch.index),
      .cfg_data          (csr_ch.data),
      .req_restart       (req_ch.restart),
      .req_elapsed_ms    (req_ch.elapsed_ms),
      .req_random_sample (req_ch.random_sample),
      .rsp_lfo_value     (rsp_ch.lfo_value),
      .rsp_cycle_wrapped (rsp_ch.cycle_wrapped)
   );

endmodule

`default_nettype wire

@@ tb/sv/clfo_lfo_checker.sv @@
`timescale 1ns / 1ps
// Checker for the curve LFO: watches the register, tick and result channels,
// predicts every result from its own oscillator copy and compares field by field.
// Depends on clfo_pkg and the channel interfaces in clfo_ifs.

module clfo_lfo_checker #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic  clock,
   input  logic  reset,
   clfo_req_if   req_mon,
   clfo_rsp_if   rsp_mon,
   clfo_csr_if   csr_mon,
   output int    fail_count,
   output int    pending
);
   import clfo_pkg::*;

   localparam int          QUARTER    = 1 << SINE_TABLE_BITS;
   localparam logic [63:0] FULL_CYCLE = 64'h1_0000_0000;
   localparam logic [63:0] PI_Q30_K   = 64'd3373259426;
   localparam int          REPORT_CAP = 40;

   typedef struct packed {
      logic [31:0] lfo_value;
      logic        cycle_wrapped;
   } lfo_output_t;

   int quarter_wave [0:QUARTER];

   logic [23:0] depth_cfg = '0;
   logic [23:0] speed_cfg = SPEED_RESET;
   logic [15:0] delay_cfg = '0;
   logic [7:0]  range_cfg = 8'd1;
   logic [2:0]  curve_cfg = CURVE_SINE;
   logic [6:0]  start_cfg = '0;

   logic [31:0] phase_acc   = '0;
   logic        osc_started = 1'b0;
   logic        osc_wrapped = 1'b0;
   logic [16:0] held_random = 17'd65536;
   logic [15:0] delay_count = '0;

   lfo_output_t lfo_outputs_due [$];
   int          errors  = 0;
   int          waiting = 0;

   assign fail_count = errors;
   assign pending    = waiting;

   // Taylor series of sin(pi/2 * k / QUARTER) in Q30, rounded to Q16.
   function automatic int quarter_sine(input int unsigned k);
      logic [63:0]        angle;
      logic [63:0]        angle_sq;
      logic [63:0]        term;
      logic [63:0]        rounded;
      logic signed [63:0] acc;
      int unsigned        n;
      angle    = (PI_Q30_K * 64'(k)) / 64'(2 * QUARTER);
      angle_sq = (angle * angle) >> 30;
      term     = angle;
      acc      = $signed(angle);
      for (n = 1; n <= 9; n++) begin
         term = (term * angle_sq) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - $signed(term);
         end else begin
            acc = acc + $signed(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      rounded = ($unsigned(acc) + 64'd8192) / 64'd16384;
      if (rounded > 64'd65536) begin
         rounded = 64'd65536;
      end
      return int'(rounded);
   endfunction

   initial begin : fill_quarter_wave
      int unsigned k;
      for (k = 0; k <= QUARTER; k++) begin
         quarter_wave[k] = quarter_sine(k);
      end
   end

   function automatic longint sine_at(input logic [31:0] ph);
      logic [SINE_TABLE_BITS-1:0] idx;
      int                         mag;
      idx = ph[29 -: SINE_TABLE_BITS];
      mag = ph[30] ? quarter_wave[QUARTER - idx] : quarter_wave[idx];
      return ph[31] ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint triangle_at(input logic [31:0] ph);
      longint t;
      t = longint'(ph >> 14);
      case (ph[31:30])
         2'd0:    return t;
         2'd3:    return t - 262144;
         default: return 131072 - t;
      endcase
   endfunction

   function automatic void clear_oscillator();
      phase_acc   = '0;
      osc_started = 1'b0;
      osc_wrapped = 1'b0;
      held_random = 17'd65536;
      delay_count = '0;
   endfunction

   function automatic void store_register(input logic [CSR_INDEX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_DEPTH: depth_cfg = value[23:0];
         REG_SPEED: speed_cfg = value[23:0];
         REG_DELAY: delay_cfg = value[15:0];
         REG_RANGE: range_cfg = value[7:0];
         REG_CURVE: curve_cfg = value[2:0];
         REG_START: start_cfg = value[6:0];
         default: ;
      endcase
   endfunction

   // Consume the start delay, advance the phase, then scale the curve sample.
   function automatic lfo_output_t step_oscillator(input logic restart,
                                                   input logic [15:0] elapsed,
                                                   input logic [15:0] sample);
      logic [63:0] ms;
      logic [63:0] incr;
      logic [63:0] base;
      logic [63:0] total;
      logic        moving;
      longint      curve;
      longint      depth_s;
      longint      value;
      lfo_output_t res;
      ms     = 64'(elapsed);
      moving = 1'b1;
      value  = 0;
      if (restart) begin
         clear_oscillator();
      end
      if (delay_count < delay_cfg) begin
         if (64'(delay_count) + ms <= 64'(delay_cfg)) begin
            delay_count = delay_count + elapsed;
            moving      = 1'b0;
         end else begin
            ms          = ms - 64'(delay_cfg - delay_count);
            delay_count = delay_cfg;
         end
      end
      if (moving && speed_cfg != 0) begin
         base = 64'(phase_acc);
         if (!osc_started) begin
            base        = (64'(start_cfg) << 32) / 64'd127;
            osc_started = 1'b1;
         end
         incr        = ((64'(speed_cfg) * ms) << 16) / 64'd1000;
         total       = base + incr;
         osc_wrapped = (total >= FULL_CYCLE);
         phase_acc   = total[31:0];
      end
      if (depth_cfg != 0 && delay_count >= delay_cfg) begin
         depth_s = longint'($signed(depth_cfg));
         case (curve_cfg)
            CURVE_SINE:   curve = sine_at(phase_acc);
            CURVE_TRI:    curve = triangle_at(phase_acc);
            CURVE_SAW:    curve = longint'(phase_acc[31:16]);
            CURVE_SQUARE: curve = phase_acc[31] ? 65536 : 0;
            CURVE_RANDOM: begin
               if (osc_wrapped) begin
                  held_random = {1'b0, sample};
               end
               curve = longint'(held_random);
            end
            default:      curve = 65536;
         endcase
         value = (curve * depth_s) / 65536;
         value = value * longint'(range_cfg);
      end
      res.lfo_value     = value[31:0];
      res.cycle_wrapped = osc_wrapped;
      return res;
   endfunction

   function automatic void note_mismatch(input string what, input longint want,
                                         input longint got);
      errors++;
      if (errors <= REPORT_CAP) begin
         $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch_channels
      lfo_output_t due;
      if (reset) begin
         depth_cfg = '0;
         speed_cfg = SPEED_RESET;
         delay_cfg = '0;
         range_cfg = 8'd1;
         curve_cfg = CURVE_SINE;
         start_cfg = '0;
         clear_oscillator();
         lfo_outputs_due.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            store_register(csr_mon.index, csr_mon.data);
         end
         if (req_mon.valid && req_mon.ready) begin
            lfo_outputs_due.push_back(step_oscillator(req_mon.restart, req_mon.elapsed_ms,
                                                      req_mon.random_sample));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (lfo_outputs_due.size() == 0) begin
               errors++;
               $display("%0t unexpected transfer: expected none, got lfo_value %0d",
                        $time, $signed(rsp_mon.lfo_value));
            end else begin
               due = lfo_outputs_due.pop_front();
               if (rsp_mon.lfo_value !== due.lfo_value) begin
                  note_mismatch("lfo_value", longint'($signed(due.lfo_value)),
                                longint'($signed(rsp_mon.lfo_value)));
               end
               if (rsp_mon.cycle_wrapped !== due.cycle_wrapped) begin
                  note_mismatch("cycle_wrapped", longint'(due.cycle_wrapped),
                                longint'(rsp_mon.cycle_wrapped));
               end
            end
         end
      end
      waiting = lfo_outputs_due.size();
   end

endmodule

@@ tb/sv/tb_curve_lfo_with_delay.sv @@
`timescale 1ns / 1ps
// Top of the curve LFO testbench: clock, reset, register setup and tick stimulus.
// Depends on clfo_pkg, clfo_ifs, the curve_lfo_with_delay block and clfo_lfo_checker.

module tb_curve_lfo_with_delay;
   import clfo_pkg::*;

   localparam int         CYCLE_LIMIT    = 400000;
   localparam int         LONG_HOLD      = 150;
   localparam int         DRAIN_CYCLES   = 24;
   localparam int         RANDOM_PHASES  = 24;
   localparam int         TICKS_PER_PHASE = 40;
   localparam logic [2:0] CURVE_FLAT_LO  = 3'd5;
   localparam logic [2:0] CURVE_FLAT_MID = 3'd6;
   localparam logic [2:0] CURVE_FLAT_HI  = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int          fail_count;
   int          pending;
   int unsigned cycle_count = 0;
   int          ticks_sent  = 0;
   int          settings    = 0;
   int          long_holds  = 0;
   bit          req_eager   = 1'b0;
   bit          rsp_eager   = 1'b0;

   clfo_req_if req_ch ();
   clfo_rsp_if rsp_ch ();
   clfo_csr_if csr_ch ();

   curve_lfo_with_delay dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   clfo_lfo_checker lfo_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_mon    (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout at cycle %0d", cycle_count);
      $display("end of test: mismatches");
      $finish;
   end

   // Receiver: hold off before each transfer (random, none when eager, or LONG_HOLD).
   always begin : rsp_drain
      int hold;
      if (long_holds > 0) begin
         hold = LONG_HOLD;
         long_holds--;
      end else if (rsp_eager) begin
         hold = 0;
      end else begin
         hold = $urandom_range(0, 12);
      end
      if (hold > 0) begin
         rsp_ch.ready <= 1'b0;
         repeat (hold) @(negedge clock);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      @(negedge clock);
   end

   task automatic send_tick(input logic restart, input logic [15:0] ms,
                            input logic [15:0] sample);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.restart       <= restart;
      req_ch.elapsed_ms    <= ms;
      req_ch.random_sample <= sample;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      @(negedge clock);
      ticks_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      @(negedge clock);
   endtask

   // Drain all outstanding results, then rewrite every register.
   task automatic configure(input logic [23:0] depth, input logic [23:0] speed,
                            input logic [15:0] delay, input logic [7:0] range_m,
                            input logic [2:0] curve, input logic [6:0] start);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_reg(REG_DEPTH, depth);
      write_reg(REG_SPEED, speed);
      write_reg(REG_DELAY, 24'(delay));
      write_reg(REG_RANGE, 24'(range_m));
      write_reg(REG_CURVE, 24'(curve));
      write_reg(REG_START, 24'(start));
      csr_ch.valid <= 1'b0;
      settings++;
   endtask

   function automatic logic [23:0] pick_depth();
      case ($urandom_range(0, 6))
         0:       return 24'h7FFFFF;
         1:       return 24'h800000;
         2:       return 24'h000000;
         3:       return 24'(65536);
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic logic [23:0] pick_speed();
      case ($urandom_range(0, 6))
         0:       return 24'h000000;
         1:       return 24'hFFFFFF;
         2:       return SPEED_RESET;
         3:       return 24'($urandom_range(1, 2000000));
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] pick_delay();
      case ($urandom_range(0, 7))
         0:       return 16'hFFFF;
         1:       return 16'($urandom());
         2, 3:    return 16'($urandom_range(1, 300));
         default: return 16'h0000;
      endcase
   endfunction

   function automatic logic [7:0] pick_range();
      case ($urandom_range(0, 4))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd1;
         default: return 8'($urandom());
      endcase
   endfunction

   function automatic logic [6:0] pick_start();
      case ($urandom_range(0, 3))
         0:       return 7'd0;
         1:       return 7'd127;
         default: return 7'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] pick_ms();
      case ($urandom_range(0, 11))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom());
         default: return 16'($urandom_range(1, 60));
      endcase
   endfunction

   initial begin : stimulus
      int phase_no;
      int k;
      req_ch.valid         <= 1'b0;
      req_ch.restart       <= 1'b0;
      req_ch.elapsed_ms    <= '0;
      req_ch.random_sample <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.index         <= '0;
      csr_ch.data          <= '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      configure(24'h7FFFFF, SPEED_RESET, 16'd0, 8'd1, CURVE_SINE, 7'd0);
      send_tick(1'b0, 16'd0, 16'h0000);
      send_tick(1'b0, 16'd40, 16'hFFFF);
      send_tick(1'b0, 16'd40, 16'h0000);
      send_tick(1'b0, 16'd40, 16'hAAAA);
      send_tick(1'b0, 16'd40, 16'h5555);
      send_tick(1'b0, 16'hFFFF, 16'hFFFF);
      send_tick(1'b1, 16'd10, 16'h0000);

      configure(24'h800000, 24'hFFFFFF, 16'd0, 8'd255, CURVE_TRI, 7'd127);
      send_tick(1'b0, 16'd1, 16'h1234);
      send_tick(1'b0, 16'd7, 16'h8000);
      send_tick(1'b0, 16'd13, 16'h7FFF);
      send_tick(1'b1, 16'd3, 16'h0001);

      // delay runs out in the middle of the fourth tick
      configure(24'h123456, SPEED_RESET, 16'd100, 8'd3, CURVE_SAW, 7'd64);
      repeat (4) send_tick(1'b0, 16'd30, 16'h0F0F);

      // delay lowered below the count already used up
      configure(24'hFF0000, SPEED_RESET, 16'd50, 8'd2, CURVE_SQUARE, 7'd0);
      send_tick(1'b0, 16'd20, 16'hF0F0);
      send_tick(1'b0, 16'd80, 16'h0000);

      configure(24'h7FFFFF, 24'hFFFFFF, 16'd0, 8'd255, CURVE_RANDOM, 7'd0);
      send_tick(1'b1, 16'd4, 16'hFFFF);

      // frozen phase keeps the wrap flag, so the random curve latches again
      configure(24'h7FFFFF, 24'h000000, 16'd0, 8'd255, CURVE_RANDOM, 7'd0);
      send_tick(1'b0, 16'd9, 16'h0000);
      send_tick(1'b0, 16'd0, 16'h5555);

      configure(24'h000000, SPEED_RESET, 16'd0, 8'd255, CURVE_FLAT_LO, 7'd0);
      send_tick(1'b0, 16'd100, 16'h3333);
      configure(24'hFFFFFF, SPEED_RESET, 16'd0, 8'd255, CURVE_FLAT_MID, 7'd0);
      send_tick(1'b0, 16'd1, 16'hCCCC);
      configure(24'h000001, SPEED_RESET, 16'd0, 8'd0, CURVE_FLAT_HI, 7'd0);
      send_tick(1'b0, 16'd1, 16'h9999);

      for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
         configure(pick_depth(), pick_speed(), pick_delay(), pick_range(),
                   3'($urandom_range(0, 7)), pick_start());
         req_eager = ($urandom_range(0, 3) == 0);
         rsp_eager = ($urandom_range(0, 3) == 0);
         if (phase_no == 5 || phase_no == 17) begin
            req_eager  = 1'b1;
            rsp_eager  = 1'b0;
            long_holds = 2;
         end
         for (k = 0; k < TICKS_PER_PHASE; k++) begin
            send_tick($urandom_range(0, 15) == 0, pick_ms(), 16'($urandom()));
         end
      end

      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d ticks under %0d register settings, covering all curve codes,",
               ticks_sent, settings);
      $display("start delay and its lowering, restart, frozen phase and output back-pressure.");
      if (fail_count == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ curve_lfo_with_delay.f @@
src/clfo_pkg.sv
src/clfo_ifs.sv
src/clfo_ctrl.sv
src/clfo_dp.sv
src/curve_lfo_with_delay.sv
tb/sv/clfo_lfo_checker.sv
tb/sv/tb_curve_lfo_with_delay.sv
